### hw/rtl/prmam_pkg.sv
package prmam_pkg;

  localparam int MAX_SIDE = 256;

  localparam int SIDE_W  = 9;
  localparam int COORD_W = 8;
  localparam int ADDR_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam int FLIP_COL_BIT = 0;
  localparam int FLIP_ROW_BIT = 1;

  typedef logic [SIDE_W-1:0]  side_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  typedef logic signed [SIDE_W:0]   mir_t;
  typedef logic signed [SIDE_W+1:0] pos_t;

  typedef enum logic [1:0] {
    ORIENT_0   = 2'd0,
    ORIENT_90  = 2'd1,
    ORIENT_180 = 2'd2,
    ORIENT_270 = 2'd3
  } orient_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PANEL_WIDTH   = 3'd0,
    REG_PANEL_HEIGHT  = 3'd1,
    REG_CANVAS_WIDTH  = 3'd2,
    REG_CANVAS_HEIGHT = 3'd3,
    REG_SOURCE_X      = 3'd4,
    REG_SOURCE_Y      = 3'd5,
    REG_ORIENTATION   = 3'd6,
    REG_MIRROR_MODE   = 3'd7
  } cfg_idx_t;

  function automatic side_t clamp_side(input logic [CFG_DATA_W-1:0] v);
    side_t res;
    res = side_t'(v);
    if (32'(v) > MAX_SIDE) begin
      res = side_t'(MAX_SIDE);
    end
    return res;
  endfunction

endpackage

### hw/rtl/prmam_in_if.sv
interface prmam_in_if;
  logic               valid;
  logic               ready;
  prmam_pkg::coord_t  panel_col;
  prmam_pkg::coord_t  panel_row;

  modport source (output valid, output panel_col, output panel_row, input ready);
  modport sink   (input valid, input panel_col, input panel_row, output ready);
endinterface

### hw/rtl/prmam_out_if.sv
interface prmam_out_if;
  logic              valid;
  logic              ready;
  logic              on_canvas;
  prmam_pkg::addr_t  canvas_address;
  prmam_pkg::addr_t  panel_index;

  modport source (output valid, output on_canvas, output canvas_address,
                  output panel_index, input ready);
  modport sink   (input valid, input on_canvas, input canvas_address,
                  input panel_index, output ready);
endinterface

### hw/rtl/prmam_cfg_if.sv
interface prmam_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [prmam_pkg::CFG_IDX_W-1:0]        index;
  logic [prmam_pkg::CFG_DATA_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/panel_rotate_mirror_address_map_unit.sv
// An accepted item passes stages 1 to 4 in order; stage 4 holds the output register.
// Throughput: one item per cycle while out_if.ready holds; the four stages advance
// independently, so a stalled output backs up the pipe one stage at a time without loss.
// Stages: mirror and panel index, rotation, offset and canvas bounds, address multiply.
// Reset (rst_n low, synchronous): all stages empty, registers back to 64x64 panel
// and canvas, zero offset, no rotation, no mirroring.
module panel_rotate_mirror_address_map_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  prmam_in_if.sink             in_if,
  prmam_out_if.source          out_if,
  prmam_cfg_if.sink            cfg_if
);

  prmam_pkg::side_t   pw_r, ph_r, cw_r, ch_r;
  prmam_pkg::coord_t  src_x_r, src_y_r;
  prmam_pkg::orient_t orient_r;
  logic [1:0]         mirror_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_r     <= prmam_pkg::clamp_side(prmam_pkg::CFG_DATA_W'(64));
      ph_r     <= prmam_pkg::clamp_side(prmam_pkg::CFG_DATA_W'(64));
      cw_r     <= prmam_pkg::clamp_side(prmam_pkg::CFG_DATA_W'(64));
      ch_r     <= prmam_pkg::clamp_side(prmam_pkg::CFG_DATA_W'(64));
      src_x_r  <= '0;
      src_y_r  <= '0;
      orient_r <= prmam_pkg::ORIENT_0;
      mirror_r <= '0;
    end else if (cfg_if.valid) begin
      case (prmam_pkg::cfg_idx_t'(cfg_if.index))
        prmam_pkg::REG_PANEL_WIDTH:   pw_r <= prmam_pkg::clamp_side(cfg_if.data);
        prmam_pkg::REG_PANEL_HEIGHT:  ph_r <= prmam_pkg::clamp_side(cfg_if.data);
        prmam_pkg::REG_CANVAS_WIDTH:  cw_r <= prmam_pkg::clamp_side(cfg_if.data);
        prmam_pkg::REG_CANVAS_HEIGHT: ch_r <= prmam_pkg::clamp_side(cfg_if.data);
        prmam_pkg::REG_SOURCE_X:      src_x_r <= cfg_if.data[prmam_pkg::COORD_W-1:0];
        prmam_pkg::REG_SOURCE_Y:      src_y_r <= cfg_if.data[prmam_pkg::COORD_W-1:0];
        prmam_pkg::REG_ORIENTATION:   orient_r <= prmam_pkg::orient_t'(cfg_if.data[1:0]);
        prmam_pkg::REG_MIRROR_MODE:   mirror_r <= cfg_if.data[1:0];
        default: ;
      endcase
    end
  end

  // stage valids and advance chain
  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4_r || out_if.ready;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_if.ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_if.valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  // stage 1: mirror in panel space, panel buffer index
  prmam_pkg::mir_t  mx_nxt, my_nxt, mx1_r, my1_r;
  logic [16:0]      pidx_full;
  prmam_pkg::addr_t pidx1_r, pidx2_r, pidx3_r, pidx4_r;

  always_comb begin
    mx_nxt = $signed({2'b00, in_if.panel_col});
    my_nxt = $signed({2'b00, in_if.panel_row});
    if (mirror_r[prmam_pkg::FLIP_COL_BIT]) begin
      mx_nxt = $signed({1'b0, pw_r}) - 10'sd1 - $signed({2'b00, in_if.panel_col});
    end
    if (mirror_r[prmam_pkg::FLIP_ROW_BIT]) begin
      my_nxt = $signed({1'b0, ph_r}) - 10'sd1 - $signed({2'b00, in_if.panel_row});
    end
  end

  assign pidx_full = {9'b0, in_if.panel_row} * {8'b0, pw_r} + {9'b0, in_if.panel_col};

  always_ff @(posedge clk) begin
    if (adv1) begin
      mx1_r   <= mx_nxt;
      my1_r   <= my_nxt;
      pidx1_r <= pidx_full[prmam_pkg::ADDR_W-1:0];
    end
  end

  // stage 2: undo mounting rotation
  prmam_pkg::pos_t mxe, mye, wm1, hm1;
  prmam_pkg::pos_t sx_nxt, sy_nxt, sx2_r, sy2_r;

  assign mxe = {mx1_r[9], mx1_r};
  assign mye = {my1_r[9], my1_r};
  assign wm1 = $signed({2'b00, pw_r}) - 11'sd1;
  assign hm1 = $signed({2'b00, ph_r}) - 11'sd1;

  always_comb begin
    case (orient_r)
      prmam_pkg::ORIENT_90: begin
        sx_nxt = mye;
        sy_nxt = wm1 - mxe;
      end
      prmam_pkg::ORIENT_180: begin
        sx_nxt = wm1 - mxe;
        sy_nxt = hm1 - mye;
      end
      prmam_pkg::ORIENT_270: begin
        sx_nxt = hm1 - mye;
        sy_nxt = mxe;
      end
      default: begin
        sx_nxt = mxe;
        sy_nxt = mye;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      sx2_r   <= sx_nxt;
      sy2_r   <= sy_nxt;
      pidx2_r <= pidx1_r;
    end
  end

  // stage 3: add source offset, check canvas bounds
  prmam_pkg::pos_t cx_nxt, cy_nxt, cx3_r, cy3_r;
  logic            ins_nxt, ins3_r;

  assign cx_nxt = $signed({3'b000, src_x_r}) + sx2_r;
  assign cy_nxt = $signed({3'b000, src_y_r}) + sy2_r;
  assign ins_nxt = (pw_r != '0) && (ph_r != '0) && !cx_nxt[10] && !cy_nxt[10] &&
                   (cx_nxt[9:0] < {1'b0, cw_r}) && (cy_nxt[9:0] < {1'b0, ch_r});

  always_ff @(posedge clk) begin
    if (adv3) begin
      cx3_r   <= cx_nxt;
      cy3_r   <= cy_nxt;
      ins3_r  <= ins_nxt;
      pidx3_r <= pidx2_r;
    end
  end

  // stage 4: linear canvas address, output register
  logic [17:0]      addr_full;
  logic             ins4_r;
  prmam_pkg::addr_t addr4_r;

  assign addr_full = {9'b0, cy3_r[8:0]} * {9'b0, cw_r} + {9'b0, cx3_r[8:0]};

  always_ff @(posedge clk) begin
    if (adv4) begin
      ins4_r  <= ins3_r;
      addr4_r <= ins3_r ? addr_full[prmam_pkg::ADDR_W-1:0] : '0;
      pidx4_r <= pidx3_r;
    end
  end

  assign out_if.valid          = v4_r;
  assign out_if.on_canvas      = ins4_r;
  assign out_if.canvas_address = addr4_r;
  assign out_if.panel_index    = pidx4_r;

  a_off_canvas_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.on_canvas |-> out_if.canvas_address == '0)
    else $error("off-canvas item carries a nonzero address");

  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> v1_r && v2_r && v3_r && v4_r && !out_if.ready)
    else $error("input stalled while the pipe has a free stage");

  a_inside_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && ins3_r |-> !cx3_r[10] && !cy3_r[10])
    else $error("negative canvas coordinate flagged inside");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !out_if.ready |=> v4_r && $stable(pidx4_r) && $stable(addr4_r))
    else $error("stalled result changed");

endmodule

### tb/sv/panel_rotate_mirror_address_map_unit_test.sv
module panel_rotate_mirror_address_map_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;

  localparam logic [1:0] FLIP_NONE = 2'd0;
  localparam logic [1:0] FLIP_COL  = 2'd1;
  localparam logic [1:0] FLIP_ROW  = 2'd2;
  localparam logic [1:0] FLIP_BOTH = 2'd3;

  typedef logic [prmam_pkg::CFG_DATA_W-1:0] cfg_data_t;

  typedef struct packed {
    logic             on_canvas;
    prmam_pkg::addr_t canvas_address;
    prmam_pkg::addr_t panel_index;
  } pixel_map_t;

  logic clk = 1'b0;
  logic rst_n;

  prmam_in_if  pix_in ();
  prmam_out_if pix_out ();
  prmam_cfg_if reg_wr ();

  panel_rotate_mirror_address_map_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (pix_in),
    .out_if (pix_out),
    .cfg_if (reg_wr)
  );

  always #6 clk = ~clk;

  prmam_pkg::side_t   pan_w = prmam_pkg::side_t'(64);
  prmam_pkg::side_t   pan_h = prmam_pkg::side_t'(64);
  prmam_pkg::side_t   cvs_w = prmam_pkg::side_t'(64);
  prmam_pkg::side_t   cvs_h = prmam_pkg::side_t'(64);
  prmam_pkg::coord_t  src_x = '0;
  prmam_pkg::coord_t  src_y = '0;
  prmam_pkg::orient_t orient = prmam_pkg::ORIENT_0;
  logic [1:0] mirror = FLIP_NONE;

  pixel_map_t pending_maps[$];
  int errors = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_phase = 0;
  int stall_mode = 0;

  function automatic prmam_pkg::side_t saturate_side(input cfg_data_t v);
    return (int'(v) > prmam_pkg::MAX_SIDE) ? prmam_pkg::side_t'(prmam_pkg::MAX_SIDE)
                                           : prmam_pkg::side_t'(v);
  endfunction

  function automatic cfg_data_t fit_side(input int v);
    return (v > prmam_pkg::MAX_SIDE) ? cfg_data_t'(prmam_pkg::MAX_SIDE) : cfg_data_t'(v);
  endfunction

  function automatic pixel_map_t map_pixel(input prmam_pkg::coord_t col,
                                           input prmam_pkg::coord_t row);
    int w, h, mx, my, sx, sy, cx, cy;
    pixel_map_t r;
    w = int'(pan_w);
    h = int'(pan_h);
    mx = mirror[prmam_pkg::FLIP_COL_BIT] ? w - 1 - int'(col) : int'(col);
    my = mirror[prmam_pkg::FLIP_ROW_BIT] ? h - 1 - int'(row) : int'(row);
    case (orient)
      prmam_pkg::ORIENT_90: begin
        sx = my;
        sy = w - 1 - mx;
      end
      prmam_pkg::ORIENT_180: begin
        sx = w - 1 - mx;
        sy = h - 1 - my;
      end
      prmam_pkg::ORIENT_270: begin
        sx = h - 1 - my;
        sy = mx;
      end
      default: begin
        sx = mx;
        sy = my;
      end
    endcase
    cx = int'(src_x) + sx;
    cy = int'(src_y) + sy;
    r.on_canvas = (w > 0) && (h > 0) && (cx >= 0) && (cy >= 0) &&
                  (cx < int'(cvs_w)) && (cy < int'(cvs_h));
    r.canvas_address = r.on_canvas ? prmam_pkg::addr_t'(cy * int'(cvs_w) + cx) : '0;
    r.panel_index = prmam_pkg::addr_t'(int'(row) * w + int'(col));
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task automatic write_reg(input prmam_pkg::cfg_idx_t idx, input cfg_data_t value);
    reg_wr.valid <= 1'b1;
    reg_wr.index <= idx;
    reg_wr.data  <= value;
    @(posedge clk);
    while (!reg_wr.ready) @(posedge clk);
    case (idx)
      prmam_pkg::REG_PANEL_WIDTH:   pan_w = saturate_side(value);
      prmam_pkg::REG_PANEL_HEIGHT:  pan_h = saturate_side(value);
      prmam_pkg::REG_CANVAS_WIDTH:  cvs_w = saturate_side(value);
      prmam_pkg::REG_CANVAS_HEIGHT: cvs_h = saturate_side(value);
      prmam_pkg::REG_SOURCE_X:      src_x = value[prmam_pkg::COORD_W-1:0];
      prmam_pkg::REG_SOURCE_Y:      src_y = value[prmam_pkg::COORD_W-1:0];
      prmam_pkg::REG_ORIENTATION:   orient = prmam_pkg::orient_t'(value[1:0]);
      prmam_pkg::REG_MIRROR_MODE:   mirror = value[1:0];
      default: ;
    endcase
  endtask

  task automatic program_map(input cfg_data_t pw, input cfg_data_t ph,
                             input cfg_data_t cw, input cfg_data_t ch,
                             input cfg_data_t sx, input cfg_data_t sy,
                             input prmam_pkg::orient_t o, input logic [1:0] m);
    write_reg(prmam_pkg::REG_PANEL_WIDTH, pw);
    write_reg(prmam_pkg::REG_PANEL_HEIGHT, ph);
    write_reg(prmam_pkg::REG_CANVAS_WIDTH, cw);
    write_reg(prmam_pkg::REG_CANVAS_HEIGHT, ch);
    write_reg(prmam_pkg::REG_SOURCE_X, sx);
    write_reg(prmam_pkg::REG_SOURCE_Y, sy);
    write_reg(prmam_pkg::REG_ORIENTATION, cfg_data_t'(o));
    write_reg(prmam_pkg::REG_MIRROR_MODE, cfg_data_t'(m));
    reg_wr.valid <= 1'b0;
  endtask

  task automatic send_pixel(input prmam_pkg::coord_t col, input prmam_pkg::coord_t row);
    int gap_len;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap_len > 0) begin
        pix_in.valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
    burst_left--;
    pix_in.valid     <= 1'b1;
    pix_in.panel_col <= col;
    pix_in.panel_row <= row;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    pending_maps.push_back(map_pixel(col, row));
  endtask

  // drop valid and let the pipe empty before touching registers
  task automatic settle();
    pix_in.valid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic test_reset_map();
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd63, 8'd63);
    send_pixel(8'd64, 8'd0);
    settle();
  endtask

  task automatic test_rotations();
    for (int o = 0; o < 4; o++) begin
      program_map(9'd5, 9'd3, 9'd10, 9'd9, 9'd2, 9'd1, prmam_pkg::orient_t'(o), o[1:0]);
      send_pixel(8'd1, 8'd2);
      settle();
    end
  endtask

  task automatic test_canvas_edges();
    program_map(9'd8, 9'd8, 9'd8, 9'd8, 9'd0, 9'd0, prmam_pkg::ORIENT_0, FLIP_NONE);
    send_pixel(8'd7, 8'd7);
    settle();
    program_map(9'd8, 9'd8, 9'd8, 9'd8, 9'd1, 9'd0, prmam_pkg::ORIENT_0, FLIP_NONE);
    send_pixel(8'd7, 8'd0);
    settle();
    program_map(9'd4, 9'd4, 9'd16, 9'd16, 9'd2, 9'd0, prmam_pkg::ORIENT_0, FLIP_COL);
    send_pixel(8'd10, 8'd1);
    settle();
  endtask

  task automatic test_zero_sides();
    program_map(9'd0, 9'd8, 9'd16, 9'd16, 9'd0, 9'd0, prmam_pkg::ORIENT_0, FLIP_NONE);
    send_pixel(8'd3, 8'd2);
    settle();
    program_map(9'd8, 9'd0, 9'd16, 9'd16, 9'd0, 9'd0, prmam_pkg::ORIENT_90, FLIP_ROW);
    send_pixel(8'd3, 8'd2);
    settle();
    program_map(9'd8, 9'd8, 9'd0, 9'd16, 9'd0, 9'd0, prmam_pkg::ORIENT_0, FLIP_NONE);
    send_pixel(8'd0, 8'd0);
    settle();
    program_map(9'd8, 9'd8, 9'd16, 9'd0, 9'd0, 9'd0, prmam_pkg::ORIENT_270, FLIP_BOTH);
    send_pixel(8'd1, 8'd1);
    settle();
  endtask

  task automatic test_saturation();
    program_map(9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 9'h100, 9'h100, prmam_pkg::ORIENT_0,
                FLIP_NONE);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd0, 8'd0);
    settle();
    program_map(9'd256, 9'd257, 9'd256, 9'd256, 9'h1FF, 9'h0FF, prmam_pkg::ORIENT_180,
                FLIP_BOTH);
    send_pixel(8'd255, 8'd0);
    settle();
  endtask

  function automatic cfg_data_t pick_side();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return cfg_data_t'($urandom_range(257, 511));
      2:       return cfg_data_t'(prmam_pkg::MAX_SIDE);
      3:       return cfg_data_t'(1);
      4:       return cfg_data_t'($urandom_range(41, 255));
      default: return cfg_data_t'($urandom_range(2, 40));
    endcase
  endfunction

  task automatic test_random_maps();
    cfg_data_t pw, ph, cw, ch, sx, sy;
    int reach;
    int n;
    prmam_pkg::coord_t col, row;
    for (int s = 0; s < 30; s++) begin
      pw = pick_side();
      ph = pick_side();
      sx = ($urandom_range(0, 4) == 0) ? cfg_data_t'($urandom)
                                       : cfg_data_t'($urandom_range(0, 15));
      sy = ($urandom_range(0, 4) == 0) ? cfg_data_t'($urandom)
                                       : cfg_data_t'($urandom_range(0, 15));
      reach = int'(saturate_side(pw));
      if (int'(saturate_side(ph)) > reach) reach = int'(saturate_side(ph));
      cw = $urandom_range(0, 1) ? pick_side()
                                : fit_side(reach + int'(sx[7:0]) - $urandom_range(0, 4));
      ch = $urandom_range(0, 1) ? pick_side()
                                : fit_side(reach + int'(sy[7:0]) - $urandom_range(0, 4));
      program_map(pw, ph, cw, ch, sx, sy, prmam_pkg::orient_t'($urandom_range(0, 3)),
                  2'($urandom_range(0, 3)));
      n = $urandom_range(10, 20);
      for (int i = 0; i < n; i++) begin
        if (pan_w != 0 && $urandom_range(0, 9) != 0)
          col = prmam_pkg::coord_t'($urandom_range(0, int'(pan_w) - 1));
        else
          col = prmam_pkg::coord_t'($urandom_range(0, 255));
        if (pan_h != 0 && $urandom_range(0, 9) != 0)
          row = prmam_pkg::coord_t'($urandom_range(0, int'(pan_h) - 1));
        else
          row = prmam_pkg::coord_t'($urandom_range(0, 255));
        send_pixel(col, row);
      end
      settle();
    end
  endtask

  always @(posedge clk) begin : result_check
    pixel_map_t want;
    if (pix_out.valid && pix_out.ready) begin
      if (pending_maps.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = pending_maps.pop_front();
        if (pix_out.on_canvas !== want.on_canvas)
          report_mismatch($sformatf("on_canvas got %0b expected %0b",
                                    pix_out.on_canvas, want.on_canvas));
        if (pix_out.canvas_address !== want.canvas_address)
          report_mismatch($sformatf("canvas_address got %0d expected %0d",
                                    pix_out.canvas_address, want.canvas_address));
        if (pix_out.panel_index !== want.panel_index)
          report_mismatch($sformatf("panel_index got %0d expected %0d",
                                    pix_out.panel_index, want.panel_index));
      end
    end
    stall_phase++;
    if (stall_phase % 96 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0:       pix_out.ready <= 1'b1;
      1:       pix_out.ready <= 1'($urandom_range(0, 1));
      default: pix_out.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) ||
        (reg_wr.valid && reg_wr.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("panel_rotate_mirror_address_map_unit regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n            <= 1'b0;
    pix_in.valid     <= 1'b0;
    pix_in.panel_col <= '0;
    pix_in.panel_row <= '0;
    reg_wr.valid     <= 1'b0;
    reg_wr.index     <= prmam_pkg::REG_PANEL_WIDTH;
    reg_wr.data      <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_map();
    test_rotations();
    test_canvas_edges();
    test_zero_sides();
    test_saturation();
    test_random_maps();
    settle();
    if (errors == 0)
      $display("panel_rotate_mirror_address_map_unit regression: pass");
    else
      $display("panel_rotate_mirror_address_map_unit regression: fail");
    $finish;
  end

endmodule
